/* rtl/gca_pkg.sv */
// Shared constants and codes for the grid cell aggregator.
`timescale 1ns / 1ps

package gca_pkg;

    // Grid geometry; the cell address is col * MAX_ROWS + row
    localparam int MAX_COLUMNS = 1024;
    localparam int MAX_ROWS    = 512;
    localparam int COL_W       = $clog2(MAX_COLUMNS);
    localparam int ROW_W       = $clog2(MAX_ROWS);
    localparam int CELLS       = MAX_COLUMNS * MAX_ROWS;
    localparam int CELL_AW     = $clog2(CELLS);

    // Payload widths
    localparam int VAL_W     = 48;
    localparam int CNT_W     = 32;
    localparam int SAMPLE_W  = 32;
    localparam int ENTRY_W   = VAL_W + CNT_W;
    localparam int DIV_CNT_W = $clog2(VAL_W);

    // Configuration registers
    localparam int MODE_W     = 3;
    localparam int COLS_W     = 11;
    localparam int ROWS_W     = 10;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;

    localparam logic [CFG_IDX_W-1:0] CFG_MODE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COLUMNS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS    = 2'd2;

    localparam logic [COLS_W-1:0] COLUMNS_RESET = 11'd900;
    localparam logic [ROWS_W-1:0] ROWS_RESET    = 10'd450;

    // Aggregate kinds; codes above MODE_COUNT act as MODE_COUNT
    localparam logic [MODE_W-1:0] MODE_MAX   = 3'd0;
    localparam logic [MODE_W-1:0] MODE_MIN   = 3'd1;
    localparam logic [MODE_W-1:0] MODE_SUM   = 3'd2;
    localparam logic [MODE_W-1:0] MODE_MEAN  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_COUNT = 3'd4;

    // Item operations
    localparam logic OP_ACCUM = 1'b0;
    localparam logic OP_READ  = 1'b1;

endpackage

/* rtl/grid_cell_aggregator.sv */
// Grid cell aggregator: per-cell max/min/sum/mean/count over one cell memory.
`timescale 1ns / 1ps
// Timing: a result strobes on done from ST_COMPUTE once start is taken; a mean read
//   first runs the bit-serial divider in ST_DIVIDE (one quotient bit per cycle).
// Flow: a new item is taken only when busy is low, so each item has its memory
//   read, then modify and write back, before the next; a mean read of a non-empty
//   cell also keeps busy high while it divides. Reset: after rst_n rises, busy stays
//   high while the cell memory is cleared one entry a cycle. Results cannot be stalled.
module grid_cell_aggregator
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [gca_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [gca_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                              start,
    output logic                              busy,
    input  logic                              op,
    input  logic [gca_pkg::COL_W-1:0]         col,
    input  logic [gca_pkg::ROW_W-1:0]         row,
    input  logic [gca_pkg::SAMPLE_W-1:0]      sample,
    output logic                              done,
    output logic [gca_pkg::VAL_W-1:0]         result_value,
    output logic [gca_pkg::CNT_W-1:0]         sample_count,
    output logic                              empty_res,
    output logic                              out_of_range
);

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_COMPUTE,
        ST_DIVIDE
    } state_t;

    state_t state_reg;

    // Configuration
    logic [gca_pkg::MODE_W-1:0] mode_reg;
    logic [gca_pkg::COLS_W-1:0] columns_reg;
    logic [gca_pkg::ROWS_W-1:0] rows_reg;

    // Item in flight
    logic                          op_reg;
    logic                          oor_reg;
    logic [gca_pkg::CELL_AW-1:0]   addr_reg;
    logic [gca_pkg::SAMPLE_W-1:0]  sample_reg;
    logic [gca_pkg::CELL_AW-1:0]   clr_addr_reg;

    // Cell memory: {value, count}
    logic [gca_pkg::ENTRY_W-1:0]   cell_mem [gca_pkg::CELLS];
    logic [gca_pkg::ENTRY_W-1:0]   rdata_reg;

    // Divider
    logic [gca_pkg::VAL_W-1:0]     quo_reg;
    logic [gca_pkg::CNT_W-1:0]     rem_reg;
    logic [gca_pkg::CNT_W-1:0]     den_reg;
    logic [gca_pkg::DIV_CNT_W-1:0] step_reg;

    // Outputs
    logic                          done_reg;
    logic [gca_pkg::VAL_W-1:0]     result_value_reg;
    logic [gca_pkg::CNT_W-1:0]     sample_count_reg;
    logic                          empty_reg;
    logic                          oor_out_reg;

    logic                          accept;
    logic                          in_range;
    logic [gca_pkg::CELL_AW-1:0]   addr_in;
    logic [gca_pkg::VAL_W-1:0]     cur_val;
    logic [gca_pkg::CNT_W-1:0]     cur_cnt;
    logic [gca_pkg::VAL_W:0]       sum_wide;
    logic [gca_pkg::VAL_W-1:0]     sample_ext;
    logic [gca_pkg::VAL_W-1:0]     val_next;
    logic [gca_pkg::CNT_W-1:0]     cnt_next;
    logic                          mem_we;
    logic [gca_pkg::CELL_AW-1:0]   mem_waddr;
    logic [gca_pkg::ENTRY_W-1:0]   mem_wdata;
    logic [gca_pkg::CNT_W:0]       trial;
    logic [gca_pkg::CNT_W:0]       trial_diff;
    logic                          quo_bit;
    logic [gca_pkg::CNT_W-1:0]     rem_next;
    logic [gca_pkg::VAL_W-1:0]     quo_next;

    assign busy   = (state_reg != ST_IDLE);
    assign accept = start && !busy;

    assign in_range = ({1'b0, col} < columns_reg) && (32'(col) < gca_pkg::MAX_COLUMNS)
                   && ({1'b0, row} < rows_reg) && (32'(row) < gca_pkg::MAX_ROWS);
    assign addr_in  = gca_pkg::CELL_AW'(gca_pkg::CELL_AW'(col)
                    * gca_pkg::CELL_AW'(gca_pkg::MAX_ROWS) + gca_pkg::CELL_AW'(row));

    assign cur_val    = rdata_reg[gca_pkg::ENTRY_W-1:gca_pkg::CNT_W];
    assign cur_cnt    = rdata_reg[gca_pkg::CNT_W-1:0];
    assign sample_ext = gca_pkg::VAL_W'(sample_reg);
    assign sum_wide   = {1'b0, cur_val} + {1'b0, sample_ext};

    // Accumulate: new value and saturating count
    always_comb
    begin
        val_next = cur_val;
        if (cur_cnt == '0)
        begin
            val_next = sample_ext;
        end
        else
        begin
            case (mode_reg) inside
                gca_pkg::MODE_MAX:
                begin
                    if (sample_ext > cur_val)
                    begin
                        val_next = sample_ext;
                    end
                end
                gca_pkg::MODE_MIN:
                begin
                    if (sample_ext < cur_val)
                    begin
                        val_next = sample_ext;
                    end
                end
                default:
                begin
                    val_next = sum_wide[gca_pkg::VAL_W] ? '1 : sum_wide[gca_pkg::VAL_W-1:0];
                end
            endcase
        end
        cnt_next = (cur_cnt == '1) ? cur_cnt : cur_cnt + 1'b1;
    end

    // One restoring division step
    always_comb
    begin
        trial      = {rem_reg, quo_reg[gca_pkg::VAL_W-1]};
        trial_diff = trial - {1'b0, den_reg};
        quo_bit    = (trial >= {1'b0, den_reg});
        rem_next   = quo_bit ? trial_diff[gca_pkg::CNT_W-1:0] : trial[gca_pkg::CNT_W-1:0];
        quo_next   = {quo_reg[gca_pkg::VAL_W-2:0], quo_bit};
    end

    // Write port: clearing sweep after reset, else accumulate write-back
    always_comb
    begin
        if (state_reg == ST_CLEAR)
        begin
            mem_we    = 1'b1;
            mem_waddr = clr_addr_reg;
            mem_wdata = '0;
        end
        else
        begin
            mem_we    = (state_reg == ST_COMPUTE) && !oor_reg && (op_reg == gca_pkg::OP_ACCUM);
            mem_waddr = addr_reg;
            mem_wdata = {val_next, cnt_next};
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            cell_mem[mem_waddr] <= mem_wdata;
        end
        if (accept)
        begin
            rdata_reg <= cell_mem[addr_in];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= gca_pkg::MODE_MAX;
            columns_reg <= gca_pkg::COLUMNS_RESET;
            rows_reg    <= gca_pkg::ROWS_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                gca_pkg::CFG_MODE:    mode_reg    <= cfg_data[gca_pkg::MODE_W-1:0];
                gca_pkg::CFG_COLUMNS: columns_reg <= cfg_data[gca_pkg::COLS_W-1:0];
                gca_pkg::CFG_ROWS:    rows_reg    <= cfg_data[gca_pkg::ROWS_W-1:0];
                default:              ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_CLEAR;
            clr_addr_reg     <= '0;
            op_reg           <= gca_pkg::OP_ACCUM;
            oor_reg          <= 1'b0;
            addr_reg         <= '0;
            sample_reg       <= '0;
            quo_reg          <= '0;
            rem_reg          <= '0;
            den_reg          <= '0;
            step_reg         <= '0;
            done_reg         <= 1'b0;
            result_value_reg <= '0;
            sample_count_reg <= '0;
            empty_reg        <= 1'b0;
            oor_out_reg      <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                ST_CLEAR:
                begin
                    clr_addr_reg <= clr_addr_reg + 1'b1;
                    if (32'(clr_addr_reg) == gca_pkg::CELLS - 1)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE:
                begin
                    if (start)
                    begin
                        op_reg     <= op;
                        oor_reg    <= !in_range;
                        addr_reg   <= addr_in;
                        sample_reg <= sample;
                        state_reg  <= ST_COMPUTE;
                    end
                end
                ST_COMPUTE:
                begin
                    state_reg        <= ST_IDLE;
                    done_reg         <= 1'b1;
                    result_value_reg <= '0;
                    sample_count_reg <= '0;
                    empty_reg        <= 1'b0;
                    oor_out_reg      <= oor_reg;
                    if (!oor_reg)
                    begin
                        if (op_reg == gca_pkg::OP_ACCUM)
                        begin
                            sample_count_reg <= cnt_next;
                        end
                        else
                        begin
                            sample_count_reg <= cur_cnt;
                            if (cur_cnt == '0)
                            begin
                                empty_reg <= 1'b1;
                            end
                            else
                            begin
                                case (mode_reg) inside
                                    gca_pkg::MODE_MAX, gca_pkg::MODE_MIN, gca_pkg::MODE_SUM:
                                    begin
                                        result_value_reg <= cur_val;
                                    end
                                    gca_pkg::MODE_MEAN:
                                    begin
                                        // hold the result until the quotient is done
                                        done_reg  <= 1'b0;
                                        quo_reg   <= cur_val;
                                        rem_reg   <= '0;
                                        den_reg   <= cur_cnt;
                                        step_reg  <= '0;
                                        state_reg <= ST_DIVIDE;
                                    end
                                    default:
                                    begin
                                        result_value_reg <= gca_pkg::VAL_W'(cur_cnt);
                                    end
                                endcase
                            end
                        end
                    end
                end
                ST_DIVIDE:
                begin
                    quo_reg  <= quo_next;
                    rem_reg  <= rem_next;
                    step_reg <= step_reg + 1'b1;
                    if (32'(step_reg) == gca_pkg::VAL_W - 1)
                    begin
                        done_reg         <= 1'b1;
                        result_value_reg <= quo_next;
                        sample_count_reg <= den_reg;
                        state_reg        <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign done         = done_reg;
    assign result_value = result_value_reg;
    assign sample_count = sample_count_reg;
    assign empty_res    = empty_reg;
    assign out_of_range = oor_out_reg;

endmodule
